// ----- rtl/coleman_liau_text_grader_defines.svh -----
// Assertion helpers for the top-level grader file
`ifndef COLEMAN_LIAU_TEXT_GRADER_DEFINES_SVH
`define COLEMAN_LIAU_TEXT_GRADER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define CLG_CHECK(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define CLG_CHECK_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/clg_pkg.sv -----
package clg_pkg;

    // Default saturation limit for the character counters
    localparam int CLG_MAX_CHARS_DEFAULT = 65535;

    // Result field widths
    localparam int CLG_GRADE_W    = 5;
    localparam int CLG_LETTER_W   = 16;
    localparam int CLG_WORD_W     = 17;
    localparam int CLG_SENTENCE_W = 16;

    // Top grade; also the first trial of the grade search
    localparam int CLG_GRADE_TOP = 16;

    // Search passes: one for the top grade, then one per lower grade bit
    localparam int CLG_PASSES = 5;
    localparam int CLG_PASS_W = 3;

    // Serial accumulator width; holds the running carry of the weighted sum
    localparam int CLG_ACC_W = 16;

    // Weights of 2*num + den - k*(2*den):
    //   1176*L - 5920*S - (3060 + 200*k)*W
    localparam int CLG_COEF_LETTER    = 1176;
    localparam int CLG_COEF_SENTENCE  = 5920;
    localparam int CLG_COEF_WORD_BASE = 3060;
    localparam int CLG_COEF_WORD_STEP = 200;

    // Grader sequencer states
    typedef enum logic [1:0] {
        CLG_IDLE,
        CLG_RUN,
        CLG_DONE
    } clg_state_t;

    // One finished result handed from the grader to the output register
    typedef struct packed {
        logic [CLG_GRADE_W-1:0]    grade;
        logic [CLG_LETTER_W-1:0]   letters;
        logic [CLG_WORD_W-1:0]     words;
        logic [CLG_SENTENCE_W-1:0] sentences;
    } clg_result_t;

endpackage

// ----- rtl/coleman_liau_text_grader.sv -----
// Channel | Handshake            | Word
// --------+----------------------+--------------------------------------------------
// in      | in_valid / in_stall  | text_byte, final_byte
// out     | out_valid / out_stall| reading_grade, letter_total, word_total,
//         |                      | sentence_total
//
// Text bytes are counted at one per cycle.
// A final byte hands its counts to a bit-serial grader, which takes one bit of the
// counts per cycle, in up to 5 passes: one per trial grade.
// Counting of the next text goes on meanwhile; only a final byte stalls while
// the grader is still busy or its result still waits to enter the output register.
// Reset is asynchronous and active low; it clears counters and handshake state.
`include "coleman_liau_text_grader_defines.svh"

module coleman_liau_text_grader #(
    parameter int MAX_CHARS = clg_pkg::CLG_MAX_CHARS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          text_byte,
    input  logic                                final_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [clg_pkg::CLG_GRADE_W-1:0]     reading_grade,
    output logic [clg_pkg::CLG_LETTER_W-1:0]    letter_total,
    output logic [clg_pkg::CLG_WORD_W-1:0]      word_total,
    output logic [clg_pkg::CLG_SENTENCE_W-1:0]  sentence_total
);
    import clg_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;

    logic [CNT_W-1:0] letters_seen_reg, letters_seen_next;
    logic [CNT_W-1:0] spaces_seen_reg, spaces_seen_next;
    logic [CNT_W-1:0] sentence_ends_seen_reg, sentence_ends_seen_next;

    logic [CNT_W-1:0] letters_upd;
    logic [CNT_W-1:0] spaces_upd;
    logic [CNT_W-1:0] sentences_upd;
    logic [CNT_W:0]   words_upd;

    logic is_letter;
    logic is_space;
    logic is_end;
    logic in_accept;
    logic start;

    logic        grader_busy;
    logic        res_valid;
    logic        res_take;
    clg_result_t result;

    logic        out_valid_reg, out_valid_next;
    clg_result_t out_word_reg;

    logic        counters_zero;
    logic        counters_in_range;
    logic        grade_in_range;

    // Classify the byte
    assign is_letter = ((text_byte >= CHAR_UPPER_A) && (text_byte <= CHAR_UPPER_Z)) ||
                       ((text_byte >= CHAR_LOWER_A) && (text_byte <= CHAR_LOWER_Z));
    assign is_space  = (text_byte == CHAR_SPACE);
    assign is_end    = (text_byte == CHAR_PERIOD) || (text_byte == CHAR_EXCLAIM) ||
                       (text_byte == CHAR_QUESTION);

    // Stall only a final byte that finds the grader occupied
    assign in_stall  = final_byte && grader_busy;
    assign in_accept = in_valid && !in_stall;
    assign start     = in_accept && final_byte;

    // Advance counters with saturation
    always_comb
    begin
        letters_upd   = letters_seen_reg;
        spaces_upd    = spaces_seen_reg;
        sentences_upd = sentence_ends_seen_reg;
        if (is_letter && (letters_seen_reg < CNT_W'(MAX_CHARS)))
        begin
            letters_upd = letters_seen_reg + 1'b1;
        end
        if (is_space && (spaces_seen_reg < CNT_W'(MAX_CHARS)))
        begin
            spaces_upd = spaces_seen_reg + 1'b1;
        end
        if (is_end && (sentence_ends_seen_reg < CNT_W'(MAX_CHARS)))
        begin
            sentences_upd = sentence_ends_seen_reg + 1'b1;
        end
        words_upd = {1'b0, spaces_upd} + (CNT_W+1)'(1);
    end

    // Hold, count, or clear after a final byte
    always_comb
    begin
        priority if (start)
        begin
            letters_seen_next       = '0;
            spaces_seen_next        = '0;
            sentence_ends_seen_next = '0;
        end
        else if (in_accept)
        begin
            letters_seen_next       = letters_upd;
            spaces_seen_next        = spaces_upd;
            sentence_ends_seen_next = sentences_upd;
        end
        else
        begin
            letters_seen_next       = letters_seen_reg;
            spaces_seen_next        = spaces_seen_reg;
            sentence_ends_seen_next = sentence_ends_seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letters_seen_reg       <= '0;
            spaces_seen_reg        <= '0;
            sentence_ends_seen_reg <= '0;
        end
        else
        begin
            letters_seen_reg       <= letters_seen_next;
            spaces_seen_reg        <= spaces_seen_next;
            sentence_ends_seen_reg <= sentence_ends_seen_next;
        end
    end

    clg_grader #(
        .MAX_CHARS (MAX_CHARS)
    ) u_grader (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .letters_in   (letters_upd),
        .sentences_in (sentences_upd),
        .words_in     (words_upd),
        .take         (res_take),
        .busy         (grader_busy),
        .res_valid    (res_valid),
        .result       (result)
    );

    // Move a finished result into the output register when it is free
    assign res_take       = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reading_grade  = out_word_reg.grade;
    assign letter_total   = out_word_reg.letters;
    assign word_total     = out_word_reg.words;
    assign sentence_total = out_word_reg.sentences;

    // Terms for the checks
    assign counters_zero     = (letters_seen_reg == '0) && (spaces_seen_reg == '0) &&
                               (sentence_ends_seen_reg == '0);
    assign counters_in_range = (letters_seen_reg <= CNT_W'(MAX_CHARS)) &&
                               (spaces_seen_reg <= CNT_W'(MAX_CHARS)) &&
                               (sentence_ends_seen_reg <= CNT_W'(MAX_CHARS));
    assign grade_in_range    = !res_valid || (result.grade <= CLG_GRADE_W'(CLG_GRADE_TOP));

    // Checks
    `CLG_CHECK_NEXT(a_clear_after_final, start, counters_zero, "counters kept after final")
    `CLG_CHECK(a_grade_range, grade_in_range, "grade above top")
    `CLG_CHECK(a_words_nonzero, !out_valid_reg || (out_word_reg.words != '0), "word total of zero")
    `CLG_CHECK(a_counter_sat, counters_in_range, "counter past limit")

endmodule

// ----- rtl/clg_grader.sv -----
module clg_grader #(
    parameter int MAX_CHARS = clg_pkg::CLG_MAX_CHARS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(MAX_CHARS+1)-1:0]        letters_in,
    input  logic [$clog2(MAX_CHARS+1)-1:0]        sentences_in,
    input  logic [$clog2(MAX_CHARS+1):0]          words_in,
    input  logic                                  take,
    output logic                                  busy,
    output logic                                  res_valid,
    output clg_pkg::clg_result_t                  result
);
    import clg_pkg::*;

    localparam int CNT_W    = $clog2(MAX_CHARS + 1);
    localparam int PASS_LEN = CNT_W + 1;
    localparam int BIT_W    = $clog2(PASS_LEN);
    localparam int SUM_W    = CLG_ACC_W + 1;

    clg_state_t state_reg, state_next;

    logic [PASS_LEN-1:0]          l_sr_reg, l_sr_next;
    logic [PASS_LEN-1:0]          s_sr_reg, s_sr_next;
    logic [PASS_LEN-1:0]          w_sr_reg, w_sr_next;
    logic signed [CLG_ACC_W-1:0]  acc_reg, acc_next;
    logic [BIT_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [CLG_PASS_W-1:0]        pass_reg, pass_next;
    logic [CLG_GRADE_W-1:0]       grade_reg, grade_next;

    logic [CLG_GRADE_W-1:0]       trial;
    logic signed [SUM_W-1:0]      coef_word;
    logic signed [SUM_W-1:0]      term;
    logic signed [SUM_W-1:0]      sum;
    logic signed [CLG_ACC_W-1:0]  acc_step;
    logic                         last_bit;
    logic                         pass_ok;
    logic                         last_pass;

    // Trial grade: bits found so far plus the bit under test
    assign trial = grade_reg | (CLG_GRADE_W'(CLG_GRADE_TOP) >> pass_reg);
    assign coef_word = SUM_W'(CLG_COEF_WORD_BASE) + SUM_W'(CLG_COEF_WORD_STEP * trial);

    // Add the weights of the current bit of each count, then halve
    always_comb
    begin
        term = '0;
        if (l_sr_reg[0])
        begin
            term = term + SUM_W'(CLG_COEF_LETTER);
        end
        if (s_sr_reg[0])
        begin
            term = term - SUM_W'(CLG_COEF_SENTENCE);
        end
        if (w_sr_reg[0])
        begin
            term = term - coef_word;
        end
        sum      = SUM_W'(acc_reg) + term;
        acc_step = CLG_ACC_W'(sum >>> 1);
    end

    // The weighted sum is non-negative exactly when the final carry is
    assign last_bit  = (bit_cnt_reg == BIT_W'(PASS_LEN - 1));
    assign pass_ok   = !acc_step[CLG_ACC_W-1];
    assign last_pass = (pass_reg == CLG_PASS_W'(CLG_PASSES - 1)) ||
                       ((pass_reg == '0) && pass_ok);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CLG_IDLE:
            begin
                if (start)
                begin
                    state_next = CLG_RUN;
                end
            end
            CLG_RUN:
            begin
                if (last_bit && last_pass)
                begin
                    state_next = CLG_DONE;
                end
            end
            CLG_DONE:
            begin
                if (take)
                begin
                    state_next = CLG_IDLE;
                end
            end
            default:
            begin
                state_next = CLG_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy      = 1'b1;
        res_valid = 1'b0;
        unique case (state_reg)
            CLG_IDLE: busy = 1'b0;
            CLG_RUN:  busy = 1'b1;
            CLG_DONE: res_valid = 1'b1;
            default:  busy = 1'b0;
        endcase
    end

    // Datapath: load counts, rotate them through one pass per trial grade
    always_comb
    begin
        l_sr_next    = l_sr_reg;
        s_sr_next    = s_sr_reg;
        w_sr_next    = w_sr_reg;
        acc_next     = acc_reg;
        bit_cnt_next = bit_cnt_reg;
        pass_next    = pass_reg;
        grade_next   = grade_reg;
        if ((state_reg == CLG_IDLE) && start)
        begin
            l_sr_next    = {1'b0, letters_in};
            s_sr_next    = {1'b0, sentences_in};
            w_sr_next    = words_in;
            acc_next     = '0;
            bit_cnt_next = '0;
            pass_next    = '0;
            grade_next   = '0;
        end
        else if (state_reg == CLG_RUN)
        begin
            l_sr_next = {l_sr_reg[0], l_sr_reg[PASS_LEN-1:1]};
            s_sr_next = {s_sr_reg[0], s_sr_reg[PASS_LEN-1:1]};
            w_sr_next = {w_sr_reg[0], w_sr_reg[PASS_LEN-1:1]};
            if (last_bit)
            begin
                acc_next     = '0;
                bit_cnt_next = '0;
                pass_next    = pass_reg + 1'b1;
                if (pass_ok)
                begin
                    grade_next = trial;
                end
            end
            else
            begin
                acc_next     = acc_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CLG_IDLE;
            bit_cnt_reg <= '0;
            pass_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            pass_reg    <= pass_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        l_sr_reg  <= l_sr_next;
        s_sr_reg  <= s_sr_next;
        w_sr_reg  <= w_sr_next;
        acc_reg   <= acc_next;
        grade_reg <= grade_next;
    end

    // Counts are back in place after whole rotations
    assign result.grade     = grade_reg;
    assign result.letters   = CLG_LETTER_W'(l_sr_reg);
    assign result.words     = CLG_WORD_W'(w_sr_reg);
    assign result.sentences = CLG_SENTENCE_W'(s_sr_reg);

endmodule

// ----- verif/testbench.sv -----
module testbench;

    import clg_pkg::*;

    // Counter saturation point of the block at its default parameter
    localparam int SAT_LIMIT = CLG_MAX_CHARS_DEFAULT;
    // Run ends with a failure past this many cycles
    localparam int CYCLE_LIMIT = 2000000;
    // Cycles to wait for stray results once nothing is due
    localparam int DRAIN_CYCLES = 200;
    // Random part length
    localparam int RANDOM_WORDS_MIN = 420;
    localparam int RANDOM_TEXTS_MIN = 40;
    // Words at the end of the run sent without any idling
    localparam int TAIL_WORDS = 40;

    // One input word plus its pacing controls
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         idle_ok;
        bit         drain;
        bit         tail;
    } char_word_t;

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] text_byte = '0;
    logic final_byte = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CLG_GRADE_W-1:0] reading_grade;
    logic [CLG_LETTER_W-1:0] letter_total;
    logic [CLG_WORD_W-1:0] word_total;
    logic [CLG_SENTENCE_W-1:0] sentence_total;

    char_word_t char_words_pending[$];
    clg_result_t grades_due[$];

    // Running counts of the text being graded
    int letters_cnt = 0;
    int spaces_cnt = 0;
    int ends_cnt = 0;

    logic in_took = 1'b0;
    logic run_tail = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;

    coleman_liau_text_grader dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reading_grade  (reading_grade),
        .letter_total   (letter_total),
        .word_total     (word_total),
        .sentence_total (sentence_total)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Coleman-Liau grade, rounded half away from zero and clamped to 0..16
    function automatic logic [CLG_GRADE_W-1:0] coleman_liau_grade(input longint letters,
                                                                  input longint words,
                                                                  input longint sentences);
        longint num;
        longint den;
        longint q;
        num = 588 * letters - 2960 * sentences - 1580 * words;
        den = 100 * words;
        if (num >= 0)
            q = (2 * num + den) / (2 * den);
        else
            q = -((-2 * num + den) / (2 * den));
        if (q < 1)
            return '0;
        else if (q >= CLG_GRADE_TOP)
            return CLG_GRADE_W'(CLG_GRADE_TOP);
        else
            return CLG_GRADE_W'(q);
    endfunction

    // Count one accepted byte; on the final byte queue the graded totals and clear
    task automatic count_text_byte(input logic [7:0] ch, input logic fin);
        clg_result_t res;
        if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))
        begin
            if (letters_cnt < SAT_LIMIT)
                letters_cnt++;
        end
        else if (ch == " ")
        begin
            if (spaces_cnt < SAT_LIMIT)
                spaces_cnt++;
        end
        else if (ch == "." || ch == "!" || ch == "?")
        begin
            if (ends_cnt < SAT_LIMIT)
                ends_cnt++;
        end
        if (fin)
        begin
            res.grade     = coleman_liau_grade(letters_cnt, spaces_cnt + 1, ends_cnt);
            res.letters   = CLG_LETTER_W'(letters_cnt);
            res.words     = CLG_WORD_W'(spaces_cnt + 1);
            res.sentences = CLG_SENTENCE_W'(ends_cnt);
            grades_due.push_back(res);
            letters_cnt = 0;
            spaces_cnt  = 0;
            ends_cnt    = 0;
        end
    endtask

    task automatic push_byte(input logic [7:0] ch, input logic fin, input bit idle_ok,
                             input bit drain);
        char_word_t w;
        w.ch      = ch;
        w.fin     = fin;
        w.idle_ok = idle_ok;
        w.drain   = drain;
        w.tail    = 1'b0;
        char_words_pending.push_back(w);
    endtask

    // Queue a whole string as one text, final flag on its last byte
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1, 1'b1, 1'b0);
    endtask

    // Queue one random text: mostly letters in words, sometimes pure noise
    task automatic push_random_text(input bit drain);
        logic [7:0] chars[$];
        int n_words;
        int max_len;
        int len;
        logic [7:0] base;
        if ($urandom_range(0, 5) == 0)
        begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
                chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n_words = $urandom_range(1, 5);
            max_len = $urandom_range(1, 14);
            for (int wd = 0; wd < n_words; wd++)
            begin
                if (wd != 0)
                    chars.push_back(" ");
                len = $urandom_range(1, max_len);
                for (int i = 0; i < len; i++)
                begin
                    base = $urandom_range(0, 1) ? "A" : "a";
                    chars.push_back(8'(base + $urandom_range(0, 25)));
                    if ($urandom_range(0, 11) == 0)
                        chars.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: chars.push_back(".");
                        1: chars.push_back("!");
                        default: chars.push_back("?");
                    endcase
                end
            end
        end
        for (int i = 0; i < chars.size(); i++)
            push_byte(chars[i], i == chars.size() - 1, 1'b1, drain && i == 0);
    endtask

    // Stimulus and end of run
    initial
    begin
        int start_size;
        int texts_made;
        rst_n = 1'b0;

        // Lone final bytes: a letter, nothing, a high byte, a space, each sentence end
        push_byte("A", 1'b1, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        push_byte(" ", 1'b1, 1'b1, 1'b0);
        push_byte(".", 1'b1, 1'b1, 1'b0);
        push_byte("!", 1'b1, 1'b1, 1'b0);
        push_byte("?", 1'b1, 1'b1, 1'b0);
        // Neighbors of the letter ranges and a high byte count as nothing
        push_byte("@", 1'b0, 1'b1, 1'b0);
        push_byte("{", 1'b0, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b1, 1'b0);
        // 15 letters, 1 sentence, 2 words: quotient is exactly 13.5
        push_text("AZazLetter Count.");

        // Random texts; the first waits for every result before it starts
        start_size = char_words_pending.size();
        texts_made = 0;
        while (char_words_pending.size() - start_size < RANDOM_WORDS_MIN
               || texts_made < RANDOM_TEXTS_MIN)
        begin
            push_random_text(texts_made == 0 || $urandom_range(0, 9) == 0);
            texts_made++;
        end

        // Last stretch runs with no idling on either side
        for (int i = char_words_pending.size() - TAIL_WORDS; i < char_words_pending.size(); i++)
        begin
            char_words_pending[i].tail    = 1'b1;
            char_words_pending[i].idle_ok = 1'b0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (char_words_pending.size() != 0 || in_valid);
        while (grades_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Driver: present the next word at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        int gap_left;
        char_word_t w;
        if (rst_n && !(in_valid && !in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (char_words_pending.size() == 0)
                in_valid <= 1'b0;
            else if (char_words_pending[0].drain && grades_due.size() != 0)
                in_valid <= 1'b0;
            else
            begin
                w = char_words_pending.pop_front();
                text_byte  <= w.ch;
                final_byte <= w.fin;
                in_valid   <= 1'b1;
                if (w.tail)
                    run_tail <= 1'b1;
                if (w.idle_ok && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 17);
            end
        end
    end

    // Receiver stall bursts, dropped in the last stretch
    always @(negedge clk)
    begin
        int stall_left;
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!run_tail && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
        end
    end

    // Monitor: check taken results, then predict from taken input words
    always @(posedge clk)
    begin
        clg_result_t exp;
        in_took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (grades_due.size() == 0)
                begin
                    $error("result with none due: grade %0d letters %0d words %0d sentences %0d",
                           reading_grade, letter_total, word_total, sentence_total);
                    fail_count++;
                end
                else
                begin
                    exp = grades_due.pop_front();
                    if (reading_grade !== exp.grade)
                    begin
                        $error("reading_grade: expected %0d, got %0d", exp.grade, reading_grade);
                        fail_count++;
                    end
                    if (letter_total !== exp.letters)
                    begin
                        $error("letter_total: expected %0d, got %0d", exp.letters, letter_total);
                        fail_count++;
                    end
                    if (word_total !== exp.words)
                    begin
                        $error("word_total: expected %0d, got %0d", exp.words, word_total);
                        fail_count++;
                    end
                    if (sentence_total !== exp.sentences)
                    begin
                        $error("sentence_total: expected %0d, got %0d",
                               exp.sentences, sentence_total);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                count_text_byte(text_byte, final_byte);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
